### rtl/core/banm_pkg.sv
package banm_pkg;

    // Geometry defaults and limits.
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int CFG_DATA_W     = 9;
    localparam int CFG_IDX_W      = 2;
    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = CFG_DATA_W'(64);
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = CFG_DATA_W'(64);

    // Result queue depth, a power of two.
    localparam int RES_FIFO_DEPTH = 8;

    // Line buffer entry layout: one bit for each of the two stored rows.
    localparam int LB_W      = 2;
    localparam int LB_UPPER  = 1;
    localparam int LB_MIDDLE = 0;

    // Mask bit positions.
    localparam int BIT_N  = 0;
    localparam int BIT_NE = 1;
    localparam int BIT_E  = 2;
    localparam int BIT_SE = 3;
    localparam int BIT_S  = 4;
    localparam int BIT_SW = 5;
    localparam int BIT_W  = 6;
    localparam int BIT_NW = 7;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH_IN_USE  = 2'd0,
        CFG_HEIGHT_IN_USE = 2'd1
    } cfg_reg_t;

    // One result beat.
    typedef struct packed {
        logic [7:0] mask;
        logic [7:0] col;
        logic [7:0] row;
        logic       last;
    } res_t;

    // Results handed from the window stage to the result queue in one cycle.
    typedef struct packed {
        logic [1:0] cnt;
        res_t       first;
        res_t       second;
    } res_push_t;

    // Window bit index is 3*row + col; row 0 is the top, col 0 the left.
    // New column enters on the right, the left column drops out.
    function automatic logic [8:0] win_shift(input logic [8:0] w, input logic top,
                                             input logic mid, input logic bot);
        logic [8:0] r;
        r = {bot, w[8], w[7], mid, w[5], w[4], top, w[2], w[1]};
        return r;
    endfunction

    // Blob mask: a corner counts only with both edge neighbors next to it.
    function automatic logic [7:0] win_mask(input logic [8:0] w);
        logic [7:0] m;
        m = '0;
        m[BIT_N]  = w[1];
        m[BIT_E]  = w[5];
        m[BIT_S]  = w[7];
        m[BIT_W]  = w[3];
        m[BIT_NE] = w[1] & w[5] & w[2];
        m[BIT_SE] = w[5] & w[7] & w[8];
        m[BIT_SW] = w[7] & w[3] & w[6];
        m[BIT_NW] = w[3] & w[1] & w[0];
        return m;
    endfunction

endpackage

### rtl/core/banm_ram.sv
module banm_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port; the read returns the old contents on a collision.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/banm_res_fifo.sv
module banm_res_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  banm_pkg::res_push_t   push,
    output logic [$clog2(banm_pkg::RES_FIFO_DEPTH+1)-1:0] level,
    output logic                  out_valid,
    input  logic                  out_ready,
    output banm_pkg::res_t        out_data
);
    import banm_pkg::*;

    localparam int PTR_W = $clog2(RES_FIFO_DEPTH);
    localparam int LVL_W = $clog2(RES_FIFO_DEPTH + 1);

    res_t             entries_reg [RES_FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic             pop;
    logic [PTR_W-1:0] wr_ptr_plus1;

    assign pop          = out_valid && out_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);

    // Up to two entries go in per cycle, one comes out.
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.cnt);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        level_next  = level_reg + LVL_W'(push.cnt) - (pop ? LVL_W'(1) : LVL_W'(0));
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            entries_reg[wr_ptr_reg] <= push.first;
        end
        if (push.cnt == 2'd2) begin
            entries_reg[wr_ptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    assign level     = level_reg;
    assign out_valid = (level_reg != '0);
    assign out_data  = entries_reg[rd_ptr_reg];

endmodule

### rtl/core/blob_autotile_neighbor_mask.sv
// A mask leaves on m_ through the window stage and the result queue after the input beat
// that completes its window, which comes one row and one column after the tile itself.
// Sustained rate is one tile beat per cycle while the result queue has room: each
// beat reads and writes back one entry of the line buffer RAM, with a forwarding
// path when a grid is one column wide. After reset a clearing pass writes zero to
// all MAX_WIDTH line buffer entries with s_ready low; width and height reset to 64.
module blob_autotile_neighbor_mask #(
    parameter int MAX_WIDTH  = banm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = banm_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [banm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [banm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_forest_bit,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [7:0]                       m_neighbor_mask,
    output logic [7:0]                       m_tile_col,
    output logic [7:0]                       m_tile_row,
    output logic                             m_frame_last
);
    import banm_pkg::*;

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WD_W   = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
    localparam int WCMP_W = (WD_W > CFG_DATA_W) ? WD_W : CFG_DATA_W;
    localparam int HCMP_W = (ROW_W > CFG_DATA_W) ? ROW_W : CFG_DATA_W;
    localparam int LVL_W  = $clog2(RES_FIFO_DEPTH + 1);
    localparam int RSV_W  = LVL_W + 1;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] width_reg, width_next;
    logic [CFG_DATA_W-1:0] height_reg, height_next;

    // Input side counters.
    logic [COL_W-1:0] col_count_reg, col_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;

    // Clearing pass.
    logic             clr_active_reg, clr_active_next;
    logic [COL_W-1:0] clr_addr_reg, clr_addr_next;

    // Window stage.
    logic             s1_valid_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic             s1_bit_reg;
    logic             s1_pad_reg;
    logic             s1_end_reg;
    logic [8:0]       window_reg, window_next;
    logic             fwd_hit_reg;
    logic [LB_W-1:0]  fwd_data_reg;

    logic [WCMP_W-1:0] width_ext;
    logic [HCMP_W-1:0] height_ext;
    logic [WD_W-1:0]   w_eff;
    logic [ROW_W-1:0]  h_eff;
    logic              in_accept;
    logic              padding;
    logic              row_end;

    logic [LB_W-1:0]  ram_rdata;
    logic [LB_W-1:0]  lb_data;
    logic [LB_W-1:0]  lb_wdata;
    logic             ram_we;
    logic [COL_W-1:0] ram_waddr;
    logic [LB_W-1:0]  ram_wdata;
    logic             up_bit;
    logic             mid_bit;
    logic [8:0]       win_base;
    logic [8:0]       win_a;
    logic [8:0]       win_b;
    res_t             res_inner;
    res_t             res_edge;
    logic             inner_ok;
    logic             edge_ok;
    res_push_t        push;
    logic [LVL_W-1:0] fifo_level;
    logic [RSV_W-1:0] reserved;
    res_t             out_res;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_WIDTH_IN_USE:  width_next  = cfg_data;
                CFG_HEIGHT_IN_USE: height_next = cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the geometry: zero acts as one, large values act as the maximum.
    assign width_ext  = WCMP_W'(width_reg);
    assign height_ext = HCMP_W'(height_reg);

    always_comb begin
        if (width_reg == '0) begin
            w_eff = WD_W'(1);
        end else if (width_ext > WCMP_W'(MAX_WIDTH)) begin
            w_eff = WD_W'(MAX_WIDTH);
        end else begin
            w_eff = WD_W'(width_ext);
        end
        if (height_reg == '0) begin
            h_eff = ROW_W'(1);
        end else if (height_ext > HCMP_W'(MAX_HEIGHT)) begin
            h_eff = ROW_W'(MAX_HEIGHT);
        end else begin
            h_eff = ROW_W'(height_ext);
        end
    end

    // Input acceptance reserves two queue slots for every item not yet pushed.
    assign reserved  = RSV_W'(fifo_level) + (s1_valid_reg ? RSV_W'(2) : RSV_W'(0));
    assign s_ready   = !clr_active_reg && (reserved <= RSV_W'(RES_FIFO_DEPTH - 2));
    assign in_accept = s_valid && s_ready;

    // Raster position bookkeeping.
    assign padding = (row_count_reg >= h_eff);
    assign row_end = ((WD_W'(col_count_reg) + WD_W'(1)) >= w_eff);

    always_comb begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (in_accept) begin
            if (row_end) begin
                col_count_next = '0;
                row_count_next = padding ? '0 : row_count_reg + ROW_W'(1);
            end else begin
                col_count_next = COL_W'(WD_W'(col_count_reg) + WD_W'(1));
            end
        end
    end

    // Clearing pass sweeps the line buffer once after reset.
    always_comb begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg) begin
            if (clr_addr_reg == COL_W'(MAX_WIDTH - 1)) begin
                clr_active_next = 1'b0;
            end else begin
                clr_addr_next = clr_addr_reg + COL_W'(1);
            end
        end
    end

    // Line buffer data, with the write of the previous beat forwarded.
    assign lb_data = fwd_hit_reg ? fwd_data_reg : ram_rdata;

    always_comb begin
        up_bit  = lb_data[LB_UPPER];
        mid_bit = lb_data[LB_MIDDLE];
        if (s1_row_reg == '0) begin
            up_bit  = 1'b0;
            mid_bit = 1'b0;
        end else if (s1_row_reg == ROW_W'(1)) begin
            up_bit = 1'b0;
        end
    end

    // The middle row moves up, the new bit becomes the middle row.
    always_comb begin
        lb_wdata            = '0;
        lb_wdata[LB_UPPER]  = mid_bit;
        lb_wdata[LB_MIDDLE] = s1_bit_reg;
    end

    always_comb begin
        ram_we    = clr_active_reg || s1_valid_reg;
        ram_waddr = clr_active_reg ? clr_addr_reg : s1_col_reg;
        ram_wdata = clr_active_reg ? '0 : lb_wdata;
    end

    banm_ram #(
        .WIDTH (LB_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_accept),
        .raddr (col_count_reg),
        .rdata (ram_rdata)
    );

    // Window shift; at a row end one more empty column is shifted in.
    always_comb begin
        win_base    = (s1_col_reg == '0) ? 9'd0 : window_reg;
        win_a       = win_shift(win_base, up_bit, mid_bit, s1_bit_reg);
        win_b       = win_shift(win_a, 1'b0, 1'b0, 1'b0);
        window_next = window_reg;
        if (s1_valid_reg) begin
            window_next = s1_end_reg ? win_b : win_a;
        end
    end

    // Results of the current beat, packed so the first slot is filled first.
    always_comb begin
        inner_ok = (s1_row_reg != '0) && (s1_col_reg != '0);
        edge_ok  = s1_end_reg && (s1_row_reg != '0);

        res_inner.mask = win_mask(win_a);
        res_inner.col  = 8'(s1_col_reg - 1'b1);
        res_inner.row  = 8'(s1_row_reg - 1'b1);
        res_inner.last = 1'b0;

        res_edge.mask = win_mask(win_b);
        res_edge.col  = 8'(s1_col_reg);
        res_edge.row  = 8'(s1_row_reg - 1'b1);
        res_edge.last = s1_pad_reg;

        push.cnt    = 2'd0;
        push.first  = inner_ok ? res_inner : res_edge;
        push.second = res_edge;
        if (s1_valid_reg) begin
            push.cnt = {1'b0, inner_ok} + {1'b0, edge_ok};
        end
    end

    banm_res_fifo u_res_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .level     (fifo_level),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_res)
    );

    assign m_neighbor_mask = out_res.mask;
    assign m_tile_col      = out_res.col;
    assign m_tile_row      = out_res.row;
    assign m_frame_last    = out_res.last;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg      <= WIDTH_RESET;
            height_reg     <= HEIGHT_RESET;
            col_count_reg  <= '0;
            row_count_reg  <= '0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            window_reg     <= '0;
            fwd_hit_reg    <= 1'b0;
        end else begin
            width_reg      <= width_next;
            height_reg     <= height_next;
            col_count_reg  <= col_count_next;
            row_count_reg  <= row_count_next;
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            s1_valid_reg   <= in_accept;
            window_reg     <= window_next;
            if (in_accept) begin
                fwd_hit_reg <= s1_valid_reg && (s1_col_reg == col_count_reg);
            end
        end
    end

    // Stage payload, captured with each accepted beat.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_col_reg   <= col_count_reg;
            s1_row_reg   <= row_count_reg;
            s1_bit_reg   <= s_forest_bit & ~padding;
            s1_pad_reg   <= padding;
            s1_end_reg   <= row_end;
            fwd_data_reg <= lb_wdata;
        end
    end

    // The queue never overflows when a beat pushes its results.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> (RSV_W'(fifo_level) + RSV_W'(push.cnt) <= RSV_W'(RES_FIFO_DEPTH)))
    else $error("result queue overflow");

    // No tile beat is taken while the line buffer is being cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !s_ready)
    else $error("input accepted during clearing pass");

    // The beat that carries the last mask of a frame returns the raster to row zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_pad_reg && s1_end_reg) |-> (row_count_reg == '0))
    else $error("frame end did not restart the raster");

    // A forwarded line buffer entry only occurs for back-to-back beats in column zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && fwd_hit_reg) |-> (s1_col_reg == '0))
    else $error("unexpected line buffer forwarding");

endmodule
